@@ hdl/ddsl_pkg.sv @@
`timescale 1ns / 1ps
// Dual drive slew limiter package: request, result and register types,
// register indexes and zone constants.
// No dependencies.
package ddsl_pkg;

	typedef struct packed {
		logic signed [7:0] main_left;
		logic signed [7:0] assist_left;
		logic signed [7:0] main_right;
		logic signed [7:0] assist_right;
	} ddsl_tick_t;

	typedef struct packed {
		logic signed [7:0] left_drive;
		logic signed [7:0] right_drive;
	} ddsl_drive_t;

	typedef struct packed {
		logic [6:0] normal_step;
		logic [6:0] fast_step;
		logic [6:0] null_band;
	} ddsl_cfg_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NULL_BAND   = 2'd2;

	localparam logic [6:0] RST_NORMAL_STEP = 7'd10;
	localparam logic [6:0] RST_FAST_STEP   = 7'd20;
	localparam logic [6:0] RST_NULL_BAND   = 7'd15;

	localparam logic signed [7:0] ASSIST_BAND = 8'sd15;
	localparam logic signed [9:0] OUTER_ZONE  = 10'sd30;
	localparam logic signed [9:0] INNER_ZONE  = 10'sd10;
	localparam logic signed [9:0] LIMIT_POS   = 10'sd127;
	localparam logic signed [9:0] LIMIT_NEG   = -10'sd127;

endpackage

@@ hdl/ddsl_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration registers of the slew limiter: normal step, fast step, null band.
// Depends on ddsl_pkg.
module ddsl_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ddsl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ddsl_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ddsl_pkg::ddsl_cfg_t                cfg
);
	import ddsl_pkg::*;

	ddsl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_step <= RST_NORMAL_STEP;
			cfg_q.fast_step   <= RST_FAST_STEP;
			cfg_q.null_band   <= RST_NULL_BAND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NORMAL_STEP: cfg_q.normal_step <= cfg_data;
				CFG_FAST_STEP:   cfg_q.fast_step   <= cfg_data;
				CFG_NULL_BAND:   cfg_q.null_band   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/ddsl_side.sv @@
`timescale 1ns / 1ps
// Next drive level of one side: request selection, zone ramp, null band, saturation.
// Depends on ddsl_pkg.
module ddsl_side (
	input  ddsl_pkg::ddsl_cfg_t cfg,
	input  logic signed [7:0]   main_val,
	input  logic signed [7:0]   assist_val,
	input  logic signed [7:0]   level,
	output logic signed [7:0]   next_level
);
	import ddsl_pkg::*;

	logic signed [7:0] req;
	logic signed [9:0] lvl_w;
	logic signed [9:0] req_w;
	logic signed [9:0] mag_w;
	logic signed [9:0] normal_w;
	logic signed [9:0] fast_w;
	logic signed [9:0] band_w;
	logic signed [9:0] up_c;
	logic signed [9:0] nxt;

	always_comb begin
		req = (main_val <= ASSIST_BAND && main_val >= -ASSIST_BAND) ? assist_val : main_val;
		lvl_w    = {{2{level[7]}}, level};
		req_w    = {{2{req[7]}}, req};
		mag_w    = req_w[9] ? -req_w : req_w;
		normal_w = {3'b000, cfg.normal_step};
		fast_w   = {3'b000, cfg.fast_step};
		band_w   = {3'b000, cfg.null_band};
		up_c     = lvl_w + ((lvl_w > INNER_ZONE || lvl_w < -INNER_ZONE) ? fast_w : normal_w);

		if (lvl_w >= OUTER_ZONE) begin
			nxt = (req_w > lvl_w) ? lvl_w + normal_w : req_w;
		end else if (lvl_w <= -OUTER_ZONE) begin
			nxt = (req_w < lvl_w) ? lvl_w - normal_w : req_w;
		end else if (req_w > lvl_w && up_c <= req_w) begin
			nxt = up_c;
		end else begin
			nxt = req_w;
		end

		if (mag_w < band_w) begin
			nxt = '0;
		end
		if (nxt > LIMIT_POS) begin
			nxt = LIMIT_POS;
		end
		if (nxt < LIMIT_NEG) begin
			nxt = LIMIT_NEG;
		end
		next_level = nxt[7:0];
	end

endmodule

@@ hdl/dual_drive_slew_limiter.sv @@
`timescale 1ns / 1ps
// Dual drive slew limiter top level: input register, per-side ramp logic, result register.
// Depends on ddsl_pkg, ddsl_cfg_regs and ddsl_side.
//
// Takes one tick request per clock cycle while tick_stall is low and returns one
// pair of drive levels per tick, through the input register and then the result
// register. The held left and right levels update in the same cycle a tick
// leaves the input register for the result register, so the next tick
// already ramps from them. A stalled result holds the input register; the
// tick side is stalled only while both registers are full. Configuration
// writes take effect on the next tick that is processed.
module dual_drive_slew_limiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick_valid,
	output logic                             tick_stall,
	input  ddsl_pkg::ddsl_tick_t             tick,
	output logic                             drive_valid,
	input  logic                             drive_stall,
	output ddsl_pkg::ddsl_drive_t            drive,
	input  logic                             cfg_we,
	input  logic [ddsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ddsl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ddsl_pkg::*;

	ddsl_cfg_t         cfg;
	ddsl_tick_t        tick_s1;
	logic              valid_s1;
	ddsl_drive_t       drive_s2;
	logic              valid_s2;
	logic signed [7:0] left_level_q;
	logic signed [7:0] right_level_q;
	logic signed [7:0] left_next;
	logic signed [7:0] right_next;
	logic              adv;
	logic              accept;

	ddsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ddsl_side u_left (
		.cfg        (cfg),
		.main_val   (tick_s1.main_left),
		.assist_val (tick_s1.assist_left),
		.level      (left_level_q),
		.next_level (left_next)
	);

	ddsl_side u_right (
		.cfg        (cfg),
		.main_val   (tick_s1.main_right),
		.assist_val (tick_s1.assist_right),
		.level      (right_level_q),
		.next_level (right_next)
	);

	assign adv        = !valid_s2 || !drive_stall;
	assign tick_stall = valid_s1 && !adv;
	assign accept     = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			left_level_q  <= '0;
			right_level_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (adv && valid_s1) begin
				left_level_q  <= left_next;
				right_level_q <= right_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
		if (adv && valid_s1) begin
			drive_s2.left_drive  <= left_next;
			drive_s2.right_drive <= right_next;
		end
	end

	assign drive_valid = valid_s2;
	assign drive       = drive_s2;

endmodule

@@ hdl/ddsl_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the dual drive slew limiter and the bind that attaches them.
// Depends on ddsl_pkg and dual_drive_slew_limiter.
module ddsl_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick_stall,
	input  logic                             drive_valid,
	input  logic                             drive_stall,
	input  ddsl_pkg::ddsl_drive_t            drive
);
	import ddsl_pkg::*;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("stalled drive result changed");

	a_no_full_scale_neg: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive.left_drive != 8'h80 && drive.right_drive != 8'h80)
		else $error("drive level outside saturation range");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!drive_valid |-> !tick_stall)
		else $error("request stalled with empty result register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> drive_valid && drive_stall)
		else $error("request stalled without a stalled result");

endmodule

bind dual_drive_slew_limiter ddsl_checker u_ddsl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_stall  (tick_stall),
	.drive_valid (drive_valid),
	.drive_stall (drive_stall),
	.drive       (drive)
);
